@@ rtl/wsfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Wheel speed frame receiver package
// Shared types and constants of the frame receiver.
// ----------------------------------------------------------------------------
package wsfr_pkg;

    localparam int FRAME_BYTES   = 14;
    localparam int LAST_POS      = FRAME_BYTES - 1;
    localparam int CRC_LAST_POS  = 10;
    localparam int CRC_HI_POS    = 11;
    localparam int CRC_LO_POS    = 12;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0]  HEAD_RESET  = 8'h30;
    localparam logic [7:0]  END_RESET   = 8'h40;
    localparam logic [7:0]  FUNC_RESET  = 8'h50;
    localparam logic [23:0] GAIN_RESET  = 24'd65536;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_HEAD_BYTE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_BYTE       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_FUNCTION = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_GAIN     = 2'd3;

    localparam int PULSE_W  = 17;
    localparam int SPEED_W  = 41;
    localparam int GAIN_W   = 24;
    localparam int M_DATA_W = 184;

    typedef enum logic [1:0] {
        ST_OK_SPEED = 2'd0,
        ST_BAD_END  = 2'd1,
        ST_BAD_CRC  = 2'd2,
        ST_OK_OTHER = 2'd3
    } status_t;

    typedef logic signed [PULSE_W-1:0] pulse_t;

    // Frame verdict handed from the collector to the scaling stage
    typedef struct packed {
        status_t     status;
        logic [7:0]  function_code;
        pulse_t      pulses1;
        pulse_t      pulses2;
        pulse_t      pulses3;
    } judge_t;

endpackage

@@ rtl/wsfr_collect.sv @@
// ----------------------------------------------------------------------------
// Frame collector
// Hunts for the head byte, stores the frame, runs the CRC-16/Modbus and
// judges the frame on its end byte into a verdict register.
// ----------------------------------------------------------------------------
module wsfr_collect
    import wsfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  head_byte,
    input  logic [7:0]  end_byte,
    input  logic [7:0]  speed_function,
    output logic        judge_valid,
    input  logic        judge_ready,
    output judge_t      judge
);

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic pulse_t make_pulses(input logic [7:0] pol,
                                           input logic [7:0] hi,
                                           input logic [7:0] lo);
        pulse_t mag;
        mag = $signed({1'b0, hi, lo});
        if (pol == 8'd0) begin
            return '0;
        end else if (pol == 8'd1) begin
            return mag;
        end else begin
            return -mag;
        end
    endfunction

    logic        in_frame_reg;
    logic [3:0]  pos_reg;
    logic [15:0] crc_reg;
    logic [7:0]  store_reg [1:CRC_LO_POS];
    logic        judge_valid_reg;
    judge_t      judge_reg;

    logic        accept;
    logic [15:0] crc_step;
    logic [15:0] crc_final;
    status_t     status_next;
    judge_t      judge_next;

    assign s_tready = !judge_valid_reg || judge_ready;
    assign accept   = s_tvalid && s_tready;

    assign crc_step  = crc_byte(crc_reg, rx_byte);
    assign crc_final = crc_byte(crc_reg, rx_byte);

    always_comb begin
        if (rx_byte != end_byte) begin
            status_next = ST_BAD_END;
        end else if (store_reg[CRC_HI_POS] != crc_final[15:8] ||
                     store_reg[CRC_LO_POS] != crc_final[7:0]) begin
            status_next = ST_BAD_CRC;
        end else if (store_reg[1] == speed_function) begin
            status_next = ST_OK_SPEED;
        end else begin
            status_next = ST_OK_OTHER;
        end
        judge_next.status        = status_next;
        judge_next.function_code = store_reg[1];
        judge_next.pulses1       = '0;
        judge_next.pulses2       = '0;
        judge_next.pulses3       = '0;
        if (status_next == ST_OK_SPEED) begin
            judge_next.pulses1 = make_pulses(store_reg[2], store_reg[3], store_reg[4]);
            judge_next.pulses2 = make_pulses(store_reg[5], store_reg[6], store_reg[7]);
            judge_next.pulses3 = make_pulses(store_reg[8], store_reg[9], store_reg[10]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg    <= 1'b0;
            pos_reg         <= '0;
            crc_reg         <= CRC_INIT;
            judge_valid_reg <= 1'b0;
        end else begin
            if (accept && in_frame_reg && pos_reg == 4'(LAST_POS)) begin
                judge_valid_reg <= 1'b1;
            end else if (judge_ready) begin
                judge_valid_reg <= 1'b0;
            end
            if (accept) begin
                if (!in_frame_reg) begin
                    if (rx_byte == head_byte) begin
                        in_frame_reg <= 1'b1;
                        pos_reg      <= 4'd1;
                        crc_reg      <= crc_byte(CRC_INIT, rx_byte);
                    end
                end else if (pos_reg < 4'(LAST_POS)) begin
                    pos_reg <= pos_reg + 4'd1;
                    if (pos_reg <= 4'(CRC_LAST_POS)) begin
                        crc_reg <= crc_step;
                    end
                end else begin
                    in_frame_reg <= 1'b0;
                    pos_reg      <= '0;
                    crc_reg      <= CRC_INIT;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && in_frame_reg && pos_reg == 4'(LAST_POS)) begin
            judge_reg <= judge_next;
        end
        for (int i = 1; i <= CRC_LO_POS; i++) begin
            if (accept && in_frame_reg && pos_reg == 4'(i)) begin
                store_reg[i] <= rx_byte;
            end
        end
    end

    assign judge_valid = judge_valid_reg;
    assign judge       = judge_reg;

endmodule

@@ rtl/wsfr_scale.sv @@
// ----------------------------------------------------------------------------
// Speed scaling stage
// Multiplies each pulse count by the gain into the result register.
// ----------------------------------------------------------------------------
module wsfr_scale
    import wsfr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                judge_valid,
    output logic                judge_ready,
    input  judge_t              judge,
    input  logic [GAIN_W-1:0]   speed_gain,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;

    logic signed [SPEED_W-1:0] gain_s;
    logic signed [SPEED_W-1:0] prod1;
    logic signed [SPEED_W-1:0] prod2;
    logic signed [SPEED_W-1:0] prod3;

    assign gain_s = $signed({{(SPEED_W-GAIN_W){1'b0}}, speed_gain});
    assign prod1  = SPEED_W'(judge.pulses1) * gain_s;
    assign prod2  = SPEED_W'(judge.pulses2) * gain_s;
    assign prod3  = SPEED_W'(judge.pulses3) * gain_s;

    assign judge_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (judge_ready) begin
            out_valid_reg <= judge_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (judge_ready && judge_valid) begin
            out_data_reg <= {prod3, prod2, prod1,
                             judge.pulses3, judge.pulses2, judge.pulses1,
                             judge.function_code, judge.status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/wheel_speed_frame_receiver_core.sv @@
// ----------------------------------------------------------------------------
// Wheel speed frame receiver core
// Serial byte stream in, one verdict transaction per received 14-byte frame.
//
// Input: s_tdata carries one received byte per transaction. While idle,
// bytes other than the head byte are dropped. After the head byte, 13 more
// bytes complete the frame; the CRC-16/Modbus covers bytes 0..10 and 13.
// Output: one transaction per frame, registered after the end byte is taken
// (verdict register, then multiplier register). Status 0 carries three
// signed pulse counts and their products with speed_gain (Q16).
// Throughput: one byte per cycle while s_tready is high.
// A stalled output holds its transaction; input keeps flowing until both the
// verdict register and the output register are occupied.
// Reset (synchronous, aresetn low) returns to head hunting, drops any
// pending result and restores register defaults. Configuration writes
// through cfg_wr_en/cfg_index/cfg_wdata take effect the next cycle.
// ----------------------------------------------------------------------------
module wheel_speed_frame_receiver_core
    import wsfr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [1:0] frame_status, [9:2] function_code, [26:10] wheel1_pulses,
    // [43:27] wheel2_pulses, [60:44] wheel3_pulses, [101:61] wheel1_speed,
    // [142:102] wheel2_speed, [183:143] wheel3_speed
    output logic [M_DATA_W-1:0]    m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [7:0]        head_byte_reg;
    logic [7:0]        end_byte_reg;
    logic [7:0]        speed_function_reg;
    logic [GAIN_W-1:0] speed_gain_reg;

    logic   judge_valid;
    logic   judge_ready;
    judge_t judge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_byte_reg      <= HEAD_RESET;
            end_byte_reg       <= END_RESET;
            speed_function_reg <= FUNC_RESET;
            speed_gain_reg     <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_HEAD_BYTE:      head_byte_reg      <= cfg_wdata[7:0];
                REG_END_BYTE:       end_byte_reg       <= cfg_wdata[7:0];
                REG_SPEED_FUNCTION: speed_function_reg <= cfg_wdata[7:0];
                REG_SPEED_GAIN:     speed_gain_reg     <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    wsfr_collect u_collect (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .rx_byte        (s_tdata),
        .head_byte      (head_byte_reg),
        .end_byte       (end_byte_reg),
        .speed_function (speed_function_reg),
        .judge_valid    (judge_valid),
        .judge_ready    (judge_ready),
        .judge          (judge)
    );

    wsfr_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .judge_valid (judge_valid),
        .judge_ready (judge_ready),
        .judge       (judge),
        .speed_gain  (speed_gain_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

@@ rtl/wsfr_checker.sv @@
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Watches the core's ports for reset, hold and result consistency.
// ----------------------------------------------------------------------------
module wsfr_checker
    import wsfr_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // only a good speed frame carries counts and speeds
    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tdata[183:10] == '0)
        else $error("non-speed result with nonzero fields");

    a_speed_follows_pulses: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[26:10] != '0 || m_tdata[101:61] == '0) &&
                     (m_tdata[43:27] != '0 || m_tdata[142:102] == '0) &&
                     (m_tdata[60:44] != '0 || m_tdata[183:143] == '0))
        else $error("speed nonzero with zero pulses");

endmodule

bind wheel_speed_frame_receiver_core wsfr_checker u_wsfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/wheel_speed_frame_receiver_core_tb.sv @@
// ----------------------------------------------------------------------------
// Wheel speed frame receiver core testbench
// Feeds serial bytes as stream transactions, mostly well-formed 14-byte
// frames with random content plus faulty frames, truncated frames and noise,
// across several register settings. A byte-level predictor of the receiver
// (CRC-16/Modbus, status priority, signed counts and Q16 scaling) queues the
// expected verdicts, and each output transaction is checked field by field.
// The sender idles in bursts and the receiver stalls on its own pattern,
// including one long hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module wheel_speed_frame_receiver_core_tb;
    import wsfr_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;

    typedef enum {
        FLAW_NONE,
        FLAW_END,
        FLAW_END_AND_CRC,
        FLAW_CRC_HI,
        FLAW_CRC_LO,
        FLAW_PAYLOAD
    } frame_flaw_t;

    // Same bit layout as m_tdata, lowest field last
    typedef struct packed {
        logic [2:0][SPEED_W-1:0] speed;
        logic [2:0][PULSE_W-1:0] pulses;
        logic [7:0]              fcode;
        status_t                 status;
    } frame_verdict_t;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'h00;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_HEAD_BYTE;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Predictor copy of registers and receiver state
    logic [7:0]        cfg_head = HEAD_RESET;
    logic [7:0]        cfg_end  = END_RESET;
    logic [7:0]        cfg_func = FUNC_RESET;
    logic [GAIN_W-1:0] cfg_gain = GAIN_RESET;
    logic              rx_in_frame = 1'b0;
    logic [3:0]        rx_pos = 4'd0;
    logic [15:0]       rx_crc = CRC_INIT;
    logic [7:0]        rx_store [FRAME_BYTES];

    frame_verdict_t verdict_q [$];
    int             mismatches = 0;
    int             rx_bytes_sent = 0;
    int             burst_left = 0;
    bit             gaps_on = 1'b1;
    int             hold_request = 0;

    wheel_speed_frame_receiver_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {8'h00, b};
        for (k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [PULSE_W-1:0] signed_count(input logic [7:0] pol,
                                                        input logic [7:0] hi,
                                                        input logic [7:0] lo);
        logic [PULSE_W-1:0] mag;
        mag = {1'b0, hi, lo};
        if (pol == 8'd0) return '0;
        if (pol == 8'd1) return mag;
        return -mag;
    endfunction

    function automatic logic [SPEED_W-1:0] scaled_speed(input logic [PULSE_W-1:0] p);
        longint ps;
        longint g;
        longint prod;
        ps = $signed(p);
        g = longint'(cfg_gain);
        prod = ps * g;
        return prod[SPEED_W-1:0];
    endfunction

    task automatic absorb_rx_byte(input logic [7:0] b);
        frame_verdict_t v;
        logic [15:0]    crc_rx;
        int             w;
        if (!rx_in_frame) begin
            if (b == cfg_head) begin
                rx_store[0] = b;
                rx_crc = crc16_update(CRC_INIT, b);
                rx_pos = 4'd1;
                rx_in_frame = 1'b1;
            end
            return;
        end
        rx_store[rx_pos] = b;
        if (rx_pos <= CRC_LAST_POS) rx_crc = crc16_update(rx_crc, b);
        if (rx_pos < LAST_POS) begin
            rx_pos = rx_pos + 4'd1;
            return;
        end
        rx_crc = crc16_update(rx_crc, b);
        crc_rx = {rx_store[CRC_HI_POS], rx_store[CRC_LO_POS]};
        v = '0;
        v.fcode = rx_store[1];
        if (b != cfg_end) v.status = ST_BAD_END;
        else if (crc_rx != rx_crc) v.status = ST_BAD_CRC;
        else if (rx_store[1] == cfg_func) v.status = ST_OK_SPEED;
        else v.status = ST_OK_OTHER;
        if (v.status == ST_OK_SPEED) begin
            for (w = 0; w < 3; w++) begin
                v.pulses[w] = signed_count(rx_store[2 + 3 * w], rx_store[3 + 3 * w],
                                           rx_store[4 + 3 * w]);
                v.speed[w] = scaled_speed(v.pulses[w]);
            end
        end
        verdict_q.push_back(v);
        rx_in_frame = 1'b0;
        rx_pos = 4'd0;
        rx_crc = CRC_INIT;
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("ERROR: %s got 0x%0h expected 0x%0h", what, got, want);
    endtask

    task automatic check_verdict(input logic [M_DATA_W-1:0] data);
        frame_verdict_t got;
        frame_verdict_t want;
        int             w;
        got = frame_verdict_t'(data);
        if (verdict_q.size() == 0) begin
            report_mismatch("unexpected transaction", data[63:0], 64'd0);
            return;
        end
        want = verdict_q.pop_front();
        if (got.status !== want.status)
            report_mismatch("frame_status", 64'(got.status), 64'(want.status));
        if (got.fcode !== want.fcode)
            report_mismatch("function_code", 64'(got.fcode), 64'(want.fcode));
        for (w = 0; w < 3; w++) begin
            if (got.pulses[w] !== want.pulses[w])
                report_mismatch($sformatf("wheel%0d_pulses", w + 1),
                                64'(got.pulses[w]), 64'(want.pulses[w]));
            if (got.speed[w] !== want.speed[w])
                report_mismatch($sformatf("wheel%0d_speed", w + 1),
                                64'(got.speed[w]), 64'(want.speed[w]));
        end
    endtask

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) check_verdict(m_tdata);
    end

    // ---------------- result side stalls ----------------

    initial begin
        int hold_left;
        int mode;
        int mode_left;
        int tick;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_tready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_tready <= (tick % 5 == 0);
                    end
                endcase
            end
        end
    end

    // ---------------- watchdog ----------------

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_rx_byte(input logic [7:0] b);
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge aclk);
        end
        if (burst_left > 0) burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        absorb_rx_byte(b);
        rx_bytes_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_frame(input frame_bytes_t f);
        int i;
        for (i = 0; i < FRAME_BYTES; i++) send_rx_byte(f[i]);
    endtask

    function automatic frame_bytes_t make_frame(input logic [7:0] func,
                                                input logic [2:0][7:0] pol,
                                                input logic [2:0][15:0] cnt,
                                                input frame_flaw_t flaw);
        frame_bytes_t f;
        logic [15:0]  crc;
        int           i;
        f[0] = cfg_head;
        f[1] = func;
        for (i = 0; i < 3; i++) begin
            f[2 + 3 * i] = pol[i];
            f[3 + 3 * i] = cnt[i][15:8];
            f[4 + 3 * i] = cnt[i][7:0];
        end
        f[LAST_POS] = cfg_end;
        crc = CRC_INIT;
        for (i = 0; i <= CRC_LAST_POS; i++) crc = crc16_update(crc, f[i]);
        crc = crc16_update(crc, f[LAST_POS]);
        f[CRC_HI_POS] = crc[15:8];
        f[CRC_LO_POS] = crc[7:0];
        case (flaw)
            FLAW_END: begin
                f[LAST_POS] ^= 8'($urandom_range(1, 255));
            end
            FLAW_END_AND_CRC: begin
                f[LAST_POS] ^= 8'($urandom_range(1, 255));
                f[CRC_HI_POS] ^= 8'($urandom_range(1, 255));
            end
            FLAW_CRC_HI: begin
                f[CRC_HI_POS] ^= 8'($urandom_range(1, 255));
            end
            FLAW_CRC_LO: begin
                f[CRC_LO_POS] ^= 8'($urandom_range(1, 255));
            end
            FLAW_PAYLOAD: begin
                i = $urandom_range(1, CRC_LAST_POS);
                f[i] ^= 8'($urandom_range(1, 255));
            end
            default: begin
            end
        endcase
        return f;
    endfunction

    function automatic logic [7:0] rand_polarity();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 8'd0;
        if (r < 6) return 8'd1;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rand_count();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic frame_bytes_t rand_frame(input frame_flaw_t flaw);
        logic [2:0][7:0]  pol;
        logic [2:0][15:0] cnt;
        logic [7:0]       func;
        int               i;
        for (i = 0; i < 3; i++) begin
            pol[i] = rand_polarity();
            cnt[i] = rand_count();
        end
        func = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : cfg_func;
        return make_frame(func, pol, cnt, flaw);
    endfunction

    // Finish any open frame, then let every verdict come out
    task automatic wait_frames_drained();
        while (rx_in_frame) send_rx_byte(8'($urandom_range(0, 255)));
        stop_sending();
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_HEAD_BYTE:      cfg_head = val[7:0];
            REG_END_BYTE:       cfg_end = val[7:0];
            REG_SPEED_FUNCTION: cfg_func = val[7:0];
            default:            cfg_gain = val[GAIN_W-1:0];
        endcase
    endtask

    task automatic set_config(input logic [7:0] head, input logic [7:0] endb,
                              input logic [7:0] func, input logic [GAIN_W-1:0] gain);
        wait_frames_drained();
        write_cfg(REG_HEAD_BYTE, CFG_DATA_W'(head));
        write_cfg(REG_END_BYTE, CFG_DATA_W'(endb));
        write_cfg(REG_SPEED_FUNCTION, CFG_DATA_W'(func));
        write_cfg(REG_SPEED_GAIN, CFG_DATA_W'(gain));
    endtask

    // ---------------- tests ----------------

    task automatic test_good_speed_frames();
        send_frame(make_frame(cfg_func, {8'd2, 8'd1, 8'd0},
                              {16'hFFFF, 16'hFFFF, 16'hFFFF}, FLAW_NONE));
        send_frame(make_frame(cfg_func, {8'd0, 8'hFF, 8'd1},
                              {16'h1234, 16'h8001, 16'h0000}, FLAW_NONE));
        send_frame(make_frame(cfg_func, {8'h80, 8'd1, 8'hFF},
                              {16'hFFFF, 16'h0001, 16'hFFFF}, FLAW_NONE));
    endtask

    task automatic test_frame_faults();
        logic [2:0][7:0]  pol;
        logic [2:0][15:0] cnt;
        pol = {8'd1, 8'd2, 8'd1};
        cnt = {16'hFFFF, 16'h00FF, 16'h5A5A};
        send_frame(make_frame(cfg_func, pol, cnt, FLAW_END));
        send_frame(make_frame(cfg_func, pol, cnt, FLAW_END_AND_CRC));
        send_frame(make_frame(cfg_func, pol, cnt, FLAW_CRC_HI));
        send_frame(make_frame(cfg_func, pol, cnt, FLAW_CRC_LO));
        send_frame(make_frame(cfg_func, pol, cnt, FLAW_PAYLOAD));
        send_frame(make_frame(cfg_func ^ 8'h01, pol, cnt, FLAW_NONE));
        send_frame(make_frame(cfg_func ^ 8'hFF, pol, cnt, FLAW_CRC_LO));
    endtask

    task automatic test_framing();
        int i;
        // bytes other than the head are dropped while hunting
        send_rx_byte(cfg_head ^ 8'h01);
        send_rx_byte(cfg_head ^ 8'h80);
        send_rx_byte(cfg_head ^ 8'hFF);
        // head value inside the frame is plain data
        send_frame(make_frame(cfg_func, {cfg_head, cfg_head, 8'd1},
                              {{cfg_head, cfg_head}, 16'h0102, {cfg_head, 8'h00}}, FLAW_NONE));
        // truncated frame swallows the start of the next one
        send_rx_byte(cfg_head);
        for (i = 0; i < 5; i++) send_rx_byte(8'($urandom_range(0, 255)));
        send_frame(rand_frame(FLAW_NONE));
        wait_frames_drained();
    endtask

    task automatic test_backpressure();
        int i;
        gaps_on = 1'b0;
        hold_request = LONG_HOLD;
        for (i = 0; i < 6; i++) send_frame(rand_frame(FLAW_NONE));
        wait_frames_drained();
        gaps_on = 1'b1;
    endtask

    task automatic run_random_traffic(input int n_bytes);
        int stop_at;
        int r;
        int i;
        stop_at = rx_bytes_sent + n_bytes;
        while (rx_bytes_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 55) send_frame(rand_frame(FLAW_NONE));
            else if (r < 62) send_frame(rand_frame(FLAW_END));
            else if (r < 66) send_frame(rand_frame(FLAW_END_AND_CRC));
            else if (r < 72) send_frame(rand_frame(FLAW_CRC_HI));
            else if (r < 78) send_frame(rand_frame(FLAW_CRC_LO));
            else if (r < 84) send_frame(rand_frame(FLAW_PAYLOAD));
            else if (r < 92) begin
                repeat ($urandom_range(1, 8)) send_rx_byte(8'($urandom_range(0, 255)));
            end else begin
                send_rx_byte(cfg_head);
                for (i = 0; i < $urandom_range(1, 12); i++)
                    send_rx_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_register_sweep();
        int ph;
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(8'h00, 8'hFF, 8'h00, '0);
                1: set_config(8'hFF, 8'h00, 8'hFF, {GAIN_W{1'b1}});
                3: set_config(8'h30, 8'h40, 8'h50, GAIN_W'(1));
                5: set_config(HEAD_RESET, END_RESET, FUNC_RESET, GAIN_RESET);
                default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)),
                                    GAIN_W'($urandom_range(0, 24'hFFFFFF)));
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            run_random_traffic(240);
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_good_speed_frames();
        test_frame_faults();
        test_framing();
        test_backpressure();
        test_register_sweep();
        wait_frames_drained();
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/wsfr_pkg.sv
rtl/wsfr_collect.sv
rtl/wsfr_scale.sv
rtl/wheel_speed_frame_receiver_core.sv
rtl/wsfr_checker.sv
verif/wheel_speed_frame_receiver_core_tb.sv
